[hw/rtl/sdbw_pkg.sv]
`timescale 1ns / 1ps

package sdbw_pkg;

    // Seconds in one day; a known bucket never holds more.
    localparam logic [16:0] DAY_MAX_SECONDS = 17'(24 * 3600);
    // Bucket code for a day whose value is not known.
    localparam logic [16:0] UNKNOWN_CODE    = 17'h1FFFF;

    localparam logic [2:0] OP_SEED    = 3'd0;
    localparam logic [2:0] OP_ADD     = 3'd1;
    localparam logic [2:0] OP_QUERY   = 3'd2;
    localparam logic [2:0] OP_RAISE   = 3'd3;
    localparam logic [2:0] OP_ADVANCE = 3'd4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [23:0] day_index;
        logic [16:0] amount_seconds;
        logic        seed_unknown;
        logic [31:0] lifetime_floor;
    } sdbw_item_t;

    typedef struct packed {
        logic        day_known;
        logic [16:0] day_seconds;
        logic        landed;
        logic [31:0] lifetime_days;
    } sdbw_result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic adv_start;
        logic sweep;
        logic look;
        logic exec;
        logic emit;
    } sdbw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_adv;
        logic sweep_last;
        logic out_free;
    } sdbw_sts_t;

endpackage

[hw/rtl/sdbw_stream_if.sv]
`timescale 1ns / 1ps

interface sdbw_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/sdbw_ram.sv]
`timescale 1ns / 1ps

module sdbw_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[hw/rtl/sdbw_ctrl.sv]
`timescale 1ns / 1ps

module sdbw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  sdbw_pkg::sdbw_sts_t sts,
    output sdbw_pkg::sdbw_cmd_t cmd
);
    import sdbw_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_SWEEP = 3'd2;
    localparam logic [2:0] ST_LOOK  = 3'd3;
    localparam logic [2:0] ST_EXEC  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign item_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.need_adv)
                begin
                    cmd.adv_start = 1'b1;
                    state_next    = ST_SWEEP;
                end
                else
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

[hw/rtl/sdbw_datapath.sv]
`timescale 1ns / 1ps

module sdbw_datapath #(
    parameter int WINDOW_DAYS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sdbw_pkg::sdbw_cmd_t    cmd,
    output sdbw_pkg::sdbw_sts_t    sts,
    input  sdbw_pkg::sdbw_item_t   item_data,
    output logic                   result_valid,
    input  logic                   result_ready,
    output sdbw_pkg::sdbw_result_t result_data
);
    import sdbw_pkg::*;

    localparam int IDX_W = (WINDOW_DAYS > 1) ? $clog2(WINDOW_DAYS) : 1;
    localparam int CNT_W = $clog2(WINDOW_DAYS + 1);
    localparam logic [IDX_W:0]   DEPTH_X = (IDX_W + 1)'(WINDOW_DAYS);
    localparam logic [23:0]      DEPTH_D = 24'(WINDOW_DAYS);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(WINDOW_DAYS);

    sdbw_item_t       item_reg;
    logic             anchor_valid_reg;
    logic [23:0]      anchor_day_reg;
    logic [IDX_W-1:0] base_reg;
    logic [IDX_W-1:0] sweep_ptr_reg;
    logic [CNT_W-1:0] sweep_cnt_reg;
    logic             fill_unknown_reg;
    logic [31:0]      lifetime_reg;
    sdbw_result_t     pend_reg;
    sdbw_result_t     out_reg;
    logic             out_valid_reg;

    logic [23:0]      shift;
    logic             ahead;
    logic             seed_ok;
    logic             wants_adv;
    logic             full_fill;
    logic [IDX_W:0]   base_diff;
    logic [IDX_W-1:0] base_back;
    logic [23:0]      day_age;
    logic             in_win;
    logic [IDX_W:0]   phys_sum;
    logic [IDX_W-1:0] phys;
    logic [IDX_W:0]   ptr_sum;
    logic [IDX_W-1:0] ptr_inc;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [16:0]      ram_wdata;
    logic [16:0]      cur;

    logic             cur_empty;
    logic [16:0]      seed_val;
    logic [17:0]      add_sum;
    logic [16:0]      add_capped;
    logic             wr_exec;
    logic [16:0]      new_val;
    logic             bump;
    logic             known;
    logic [31:0]      lifetime_new;

    // Window bookkeeping.
    assign shift   = item_reg.day_index - anchor_day_reg;
    assign ahead   = item_reg.day_index > anchor_day_reg;
    assign seed_ok = item_reg.seed_unknown || (item_reg.amount_seconds <= DAY_MAX_SECONDS);

    assign wants_adv = ((item_reg.opcode == OP_SEED) && seed_ok)
                    || ((item_reg.opcode == OP_ADD) && (item_reg.amount_seconds != '0))
                    || (item_reg.opcode == OP_ADVANCE);

    assign full_fill = !anchor_valid_reg || (shift >= DEPTH_D);

    // Moving the window forward by a partial shift moves the base back, modulo the depth.
    assign base_diff = {1'b0, base_reg} - {1'b0, shift[IDX_W-1:0]};
    assign base_back = base_diff[IDX_W] ? IDX_W'(base_diff + DEPTH_X) : base_diff[IDX_W-1:0];

    assign day_age  = anchor_day_reg - item_reg.day_index;
    assign in_win   = anchor_valid_reg && !ahead && (day_age < DEPTH_D);
    assign phys_sum = {1'b0, base_reg} + {1'b0, day_age[IDX_W-1:0]};
    assign phys     = (phys_sum >= DEPTH_X) ? IDX_W'(phys_sum - DEPTH_X) : phys_sum[IDX_W-1:0];

    assign ptr_sum = {1'b0, sweep_ptr_reg} + {{IDX_W{1'b0}}, 1'b1};
    assign ptr_inc = (ptr_sum == DEPTH_X) ? '0 : ptr_sum[IDX_W-1:0];

    assign sts.need_adv   = wants_adv && (!anchor_valid_reg || ahead);
    assign sts.sweep_last = (sweep_cnt_reg == CNT_W'(1));
    assign sts.out_free   = !out_valid_reg || result_ready;

    // Per-operation update of the addressed bucket.
    assign cur_empty  = (cur == '0) || (cur == UNKNOWN_CODE);
    assign seed_val   = item_reg.seed_unknown ? UNKNOWN_CODE : item_reg.amount_seconds;
    assign add_sum    = {1'b0, (cur_empty ? 17'd0 : cur)} + {1'b0, item_reg.amount_seconds};
    assign add_capped = (add_sum > {1'b0, DAY_MAX_SECONDS}) ? DAY_MAX_SECONDS : add_sum[16:0];

    always_comb
    begin
        wr_exec      = 1'b0;
        new_val      = seed_val;
        bump         = 1'b0;
        known        = 1'b0;
        lifetime_new = lifetime_reg;
        case (item_reg.opcode)
            OP_SEED:
            begin
                wr_exec = seed_ok && in_win;
                new_val = seed_val;
                bump    = wr_exec && cur_empty && (seed_val != '0) && (seed_val != UNKNOWN_CODE);
            end
            OP_ADD:
            begin
                wr_exec = (item_reg.amount_seconds != '0) && in_win;
                new_val = add_capped;
                bump    = wr_exec && cur_empty;
            end
            OP_QUERY:
            begin
                known = in_win && (cur != UNKNOWN_CODE);
            end
            OP_RAISE:
            begin
                if (item_reg.lifetime_floor > lifetime_reg)
                begin
                    lifetime_new = item_reg.lifetime_floor;
                end
            end
            default:
            begin
                wr_exec = 1'b0;
            end
        endcase
        if (bump && (lifetime_reg != '1))
        begin
            lifetime_new = lifetime_reg + 32'd1;
        end
    end

    assign ram_we    = cmd.sweep || (cmd.exec && wr_exec);
    assign ram_waddr = cmd.sweep ? sweep_ptr_reg : phys;
    assign ram_wdata = cmd.sweep ? (fill_unknown_reg ? UNKNOWN_CODE : 17'd0) : new_val;

    sdbw_ram #(
        .WIDTH (17),
        .DEPTH (WINDOW_DAYS)
    ) u_bucket_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.look),
        .raddr (phys),
        .rdata (cur)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_valid_reg <= 1'b0;
            anchor_day_reg   <= '0;
            base_reg         <= '0;
            sweep_cnt_reg    <= '0;
            lifetime_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.adv_start)
            begin
                anchor_valid_reg <= 1'b1;
                anchor_day_reg   <= item_reg.day_index;
                if (full_fill)
                begin
                    sweep_cnt_reg <= DEPTH_C;
                end
                else
                begin
                    base_reg      <= base_back;
                    sweep_cnt_reg <= shift[CNT_W-1:0];
                end
            end
            else if (cmd.sweep)
            begin
                sweep_cnt_reg <= sweep_cnt_reg - CNT_W'(1);
            end
            if (cmd.exec)
            begin
                lifetime_reg <= lifetime_new;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item_data;
        end
        if (cmd.adv_start)
        begin
            fill_unknown_reg <= full_fill;
            sweep_ptr_reg    <= full_fill ? '0 : base_back;
        end
        else if (cmd.sweep)
        begin
            sweep_ptr_reg <= ptr_inc;
        end
        if (cmd.exec)
        begin
            pend_reg.day_known     <= known;
            pend_reg.day_seconds   <= known ? cur : 17'd0;
            pend_reg.landed        <= wr_exec;
            pend_reg.lifetime_days <= lifetime_new;
        end
        if (cmd.emit)
        begin
            out_reg <= pend_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;
endmodule

[hw/rtl/sliding_day_bucket_window.sv]
`timescale 1ns / 1ps

// Channel   Role   Payload        Transaction
// item      sink   sdbw_item_t    one operation: seed, add, query, raise or advance
// result    source sdbw_result_t  one report per operation, in operation order
//
// A transaction steps through check, lookup, execute and done; one that moves the
// window also sweeps after check, zeroing or marking unknown each bucket that
// enters (the shift, or WINDOW_DAYS for a large jump or the first anchor). The
// order follows the bucket RAM's single write port and registered read. After reset
// the bucket contents are not cleared: no bucket value is used before the first
// anchor, which sweeps the whole window. A finished report waits in the output
// register; a stalled result channel holds the next transaction in its done state.

module sliding_day_bucket_window #(
    parameter int WINDOW_DAYS = 64
) (
    input logic          clk,
    input logic          rst_n,
    sdbw_stream_if.sink   item,
    sdbw_stream_if.source result
);
    import sdbw_pkg::*;

    sdbw_cmd_t cmd;
    sdbw_sts_t sts;

    // The controller sequences each transaction through check, a sweep if it moves
    // the window, lookup, execute and report; the datapath owns the anchor, the circular
    // bucket RAM, the lifetime count and the output register.
    sdbw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Buckets live in a circular buffer: bucket k sits at (base + k) mod WINDOW_DAYS,
    // so a short forward move rewinds the base and zeroes only the entries that enter.
    sdbw_datapath #(
        .WINDOW_DAYS (WINDOW_DAYS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .item_data    (item.payload),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .result_data  (result.payload)
    );
endmodule
